>>> src/gdrg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generator droop ramp governor package
// Shared types and constants for the generator regulator block.
// ----------------------------------------------------------------------------
package gdrg_pkg;

  localparam int unsigned POWER_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_DROOP = 2'd0,
    CMD_GOV   = 2'd1,
    CMD_EXC   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_SLACK   = 3'd0,
    MODE_MANUAL  = 3'd1,
    MODE_WIND    = 3'd2,
    MODE_SOLAR   = 3'd3,
    MODE_HYDRO   = 3'd4,
    MODE_THERMAL = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_TARGET   = 3'd1,
    REG_MIN      = 3'd2,
    REG_MAX      = 3'd3,
    REG_DROOP    = 3'd4,
    REG_RAMP     = 3'd5,
    REG_TVOLT    = 3'd6,
    REG_STRENGTH = 3'd7
  } reg_idx_t;

  localparam logic signed [31:0] MAX_POWER_RST = 32'sd51200000;
  localparam logic [15:0] DROOP_RST = 16'd5120;
  localparam logic [30:0] RAMP_RST = 31'd128000;
  localparam logic [17:0] VOLT_ONE = 18'd65536;
  localparam logic [15:0] STRENGTH_RST = 16'd4096;

  localparam int K_GOV = 7864;
  localparam int K_EXC = 5243;
  localparam int K_WIND_AR = 60293;
  localparam int WALK_LIM = 22938;
  localparam int SCALE_LO = 13107;
  localparam int SCALE_HI = 81920;

endpackage : gdrg_pkg
`default_nettype wire

>>> src/generator_droop_ramp_governor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generator droop ramp governor
// Droop, governor, exciter and profile tick operations on one shared
// multiply, add and clamp unit under a small sequencer.
// ----------------------------------------------------------------------------
// Channel | Direction | Word
// in_     | in        | cmd, freq_hz, nominal_hz, rand_first, rand_second
// out_    | out       | out_power, out_goal, out_voltage
// cfg_    | in        | register index and write data
// Result timing depends on the operation: an exciter step or any slack-mode
// operation is shortest, droop and governor steps add a clamp step, a profile
// tick takes longer and a wind tick longest, set by the multiplier passes.
// The next word can be accepted in the cycle after the result is registered.
// Reset is synchronous and active low and restores the configuration, regulator and handshake registers and the state.
// A finished word waits in its last step until the result register is free.
module generator_droop_ramp_governor_top #(
  parameter int unsigned POWER_WIDTH = gdrg_pkg::POWER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd[1:0], freq_hz[25:2], nominal_hz[49:26], rand_first[65:50],
  // rand_second[81:66], zero fill [87:82]
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_power[31:0], out_goal[63:32], out_voltage[81:64], zero fill [87:82]
  output logic [87:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import gdrg_pkg::*;

  localparam int PW = POWER_WIDTH;
  localparam int AW = PW + 34;
  localparam int MAW = 27;
  localparam int MBW = (PW + 1 > 33) ? PW + 1 : 33;
  localparam int PRW = MAW + MBW;

  localparam logic [3:0] STEP_GOAL   = 4'd1;
  localparam logic [3:0] STEP_POWER  = 4'd2;
  localparam logic [3:0] STEP_AIM    = 4'd3;
  localparam logic [3:0] STEP_SETTLE = 4'd4;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MUL   = 10'b0000000010,
    ST_APPLY = 10'b0000000100,
    ST_OUT   = 10'b0000001000,
    ST_W1    = 10'b0000010000,
    ST_W2    = 10'b0000100000,
    ST_W3    = 10'b0001000000,
    ST_S1    = 10'b0010000000,
    ST_T1    = 10'b0100000000,
    ST_T2    = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [2:0] mode_r;
  logic signed [31:0] target_r, min_r, max_r;
  logic [15:0] droop_r, strength_r;
  logic [30:0] ramp_r;
  logic [17:0] tvolt_r;
  logic signed [PW-1:0] power_r, goal_r;
  logic [17:0] volt_r;
  logic signed [16:0] walk_r;
  logic [1:0] cmd_r;
  logic [15:0] u1_r, u2_r;
  logic signed [AW-1:0] acc_r;
  logic signed [MAW-1:0] ma_r;
  logic signed [MBW-1:0] mb_r;
  logic [3:0] step_r;
  logic [4:0] sh_r;
  logic out_v_r;
  logic [87:0] out_d_r;

  logic signed [PRW-1:0] prod;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] lim_lo, lim_hi, plimit, pw_top;

  function automatic logic signed [AW-1:0] rshift(input logic signed [AW-1:0] x,
                                                   input logic [4:0] k);
    logic signed [AW-1:0] v;
    v = x + (AW'(1) <<< (k - 5'd1));
    rshift = v >>> k;
  endfunction

  function automatic logic signed [AW-1:0] clampf(input logic signed [AW-1:0] x,
      input logic signed [AW-1:0] lo, input logic signed [AW-1:0] hi);
    logic signed [AW-1:0] y;
    y = x;
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    clampf = y;
  endfunction

  assign prod = ma_r * mb_r;
  assign rnd = rshift(acc_r, sh_r);
  assign pw_top = (AW'(1) <<< (PW - 1)) - AW'(1);
  assign lim_lo = AW'(min_r);
  assign lim_hi = AW'(max_r);
  assign plimit = clampf(clampf(rnd, lim_lo, lim_hi), -pw_top - AW'(1), pw_top);

  wire busy = (state_r != ST_IDLE);
  assign in_tready = !busy;
  assign cfg_ready = !busy;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  wire slack = (mode_r == MODE_SLACK);
  wire signed [AW-1:0] ramp_s = AW'($signed({1'b0, ramp_r}));

  always_ff @(posedge clk) begin
    logic signed [AW-1:0] scale_c, t1, t2;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= MODE_MANUAL;
      target_r <= '0; min_r <= '0; max_r <= MAX_POWER_RST;
      droop_r <= DROOP_RST; ramp_r <= RAMP_RST; tvolt_r <= VOLT_ONE;
      strength_r <= STRENGTH_RST;
      power_r <= '0; goal_r <= '0; volt_r <= VOLT_ONE; walk_r <= '0;
      out_v_r <= 1'b0; step_r <= '0;
    end else begin
      if (state_r == ST_OUT && (!out_v_r || out_tready)) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE: mode_r <= cfg_data[2:0];
          REG_TARGET: target_r <= cfg_data;
          REG_MIN: min_r <= cfg_data;
          REG_MAX: max_r <= cfg_data;
          REG_DROOP: droop_r <= cfg_data[15:0];
          REG_RAMP: ramp_r <= cfg_data[30:0];
          REG_TVOLT: tvolt_r <= cfg_data[17:0];
          REG_STRENGTH: strength_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          cmd_r <= in_tdata[1:0];
          u1_r <= in_tdata[65:50];
          u2_r <= in_tdata[81:66];
          step_r <= '0;
          state_r <= ST_MUL;
          sh_r <= 5'd16;
          case (cmd_t'(in_tdata[1:0]))
            CMD_DROOP: begin
              ma_r <= MAW'($signed({1'b0, droop_r})) * MAW'(1000);
              mb_r <= MBW'($signed({1'b0, in_tdata[25:2]}))
                    - MBW'($signed({1'b0, in_tdata[49:26]}));
            end
            CMD_GOV: begin
              ma_r <= MAW'(K_GOV);
              mb_r <= MBW'(goal_r) - MBW'(power_r);
            end
            CMD_EXC: begin
              ma_r <= MAW'(K_EXC);
              mb_r <= MBW'($signed({1'b0, tvolt_r})) - MBW'($signed({1'b0, volt_r}));
            end
            default: begin
              ma_r <= MAW'(K_WIND_AR);
              mb_r <= MBW'(walk_r);
            end
          endcase
        end
        ST_MUL: begin
          acc_r <= AW'(prod);
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          state_r <= ST_OUT;
          case (cmd_t'(cmd_r))
            CMD_DROOP: if (!slack) begin
              acc_r <= (AW'(target_r) - rnd) <<< 1;
              sh_r <= 5'd1;
              state_r <= ST_T2;
              step_r <= STEP_GOAL;
            end
            CMD_GOV: if (!slack) begin
              acc_r <= (AW'(power_r) + clampf(rnd, -ramp_s, ramp_s)) <<< 1;
              sh_r <= 5'd1;
              state_r <= ST_T2;
              step_r <= STEP_POWER;
            end
            CMD_EXC: begin
              if (slack) volt_r <= tvolt_r;
              else volt_r <= 18'(clampf(AW'($signed({1'b0, volt_r})) + rnd,
                                        '0, AW'(18'h3FFFF)));
            end
            default: if (!slack) begin
              acc_r <= rnd;
              state_r <= ST_W1;
              ma_r <= MAW'($signed({1'b0, u1_r}));
              case (mode_r)
                MODE_WIND: mb_r <= MBW'(10486);
                MODE_SOLAR: mb_r <= MBW'(26214);
                MODE_HYDRO: mb_r <= MBW'(7209);
                default: mb_r <= MBW'(3277);
              endcase
            end
          endcase
        end
        ST_W1: begin
          t1 = rshift(AW'(prod), 5'd16);
          case (mode_r)
            MODE_WIND: t1 = t1 - AW'(5243);
            MODE_SOLAR: t1 = t1 - AW'(13107);
            MODE_HYDRO: t1 = t1 - AW'(3277);
            default: t1 = t1 - AW'(1311);
          endcase
          ma_r <= MAW'(t1);
          mb_r <= MBW'($signed({1'b0, strength_r}));
          state_r <= ST_W2;
        end
        ST_W2: begin
          t2 = rshift(AW'(prod), 5'd12);
          case (mode_r)
            MODE_WIND: begin
              t1 = clampf(acc_r + t2, -AW'(WALK_LIM), AW'(WALK_LIM));
              walk_r <= 17'(t1);
              acc_r <= AW'(45875) + t1 - AW'(3277);
              ma_r <= MAW'($signed({1'b0, u2_r}));
              mb_r <= MBW'(6554);
              state_r <= ST_W3;
            end
            MODE_SOLAR: begin acc_r <= AW'(51118) + t2; state_r <= ST_S1; end
            MODE_HYDRO: begin acc_r <= AW'(60293) + t2; state_r <= ST_S1; end
            MODE_THERMAL: begin acc_r <= AW'(65536) + t2; state_r <= ST_S1; end
            default: begin acc_r <= AW'(65536); state_r <= ST_S1; end
          endcase
        end
        ST_W3: begin
          acc_r <= acc_r + rshift(AW'(prod), 5'd16);
          state_r <= ST_S1;
        end
        ST_S1: begin
          scale_c = clampf(acc_r, AW'(SCALE_LO), AW'(SCALE_HI));
          ma_r <= MAW'(scale_c);
          mb_r <= MBW'(target_r);
          state_r <= ST_T1;
        end
        ST_T1: begin
          acc_r <= AW'(prod);
          sh_r <= 5'd16;
          step_r <= STEP_AIM;
          state_r <= ST_T2;
        end
        ST_T2: begin
          state_r <= ST_OUT;
          case (step_r)
            STEP_GOAL: goal_r <= PW'(plimit);
            STEP_POWER: power_r <= PW'(plimit);
            STEP_AIM: begin
              t1 = plimit - AW'(power_r);
              acc_r <= (AW'(power_r) + clampf(t1, -ramp_s, ramp_s)) <<< 1;
              sh_r <= 5'd1;
              step_r <= STEP_SETTLE;
              state_r <= ST_T2;
            end
            default: begin
              power_r <= PW'(plimit);
              goal_r <= PW'(plimit);
            end
          endcase
        end
        ST_OUT: if (!out_v_r || out_tready) begin
          out_d_r <= {6'd0, volt_r, 32'(goal_r), 32'(power_r)};
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accepted while busy");
  a_out_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_v_r || out_tready)) |=> out_v_r)
    else $error("result lost");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> state_r == ST_IDLE) else $error("config while busy");
`endif

endmodule : generator_droop_ramp_governor_top
`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Generator droop ramp governor testbench
// Drives droop, governor, exciter and profile tick words through the
// stream ports under random idling, predicts every result word from its own
// model of the regulator and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
  import gdrg_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  generator_droop_ramp_governor_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [17:0] voltage;
    logic [31:0] goal;
    logic [31:0] power;
  } reading_t;

  logic [87:0] pending_words[$];
  reading_t expected_readings[$];

  logic [2:0] mode_r;
  longint target_r, min_r, max_r, droop_r, ramp_r, tvolt_r, strength_r;
  longint power_s, goal_s, volt_s, walk_s;

  int errors = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  int send_gap = 0;
  int take_gap = 0;
  int cmd_count[4] = '{0, 0, 0, 0};

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint round_shift(longint x, int k);
    longint v;
    v = x + (longint'(1) << (k - 1));
    if (v >= 0) return v >>> k;
    return -((-v + ((longint'(1) << k) - 1)) >>> k);
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return x;
  endfunction

  function automatic longint bound_power(longint x);
    return clip(clip(x, min_r, max_r), -(longint'(1) <<< 31),
                (longint'(1) <<< 31) - 1);
  endfunction

  function automatic longint scaled_draw(longint u, longint a, longint span);
    return a + round_shift(u * span, 16);
  endfunction

  function automatic longint strength_of(longint x);
    return round_shift(x * strength_r, 12);
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] d);
    case (reg_idx_t'(idx))
      REG_MODE: mode_r = d[2:0];
      REG_TARGET: target_r = longint'(signed'(d));
      REG_MIN: min_r = longint'(signed'(d));
      REG_MAX: max_r = longint'(signed'(d));
      REG_DROOP: droop_r = d[15:0];
      REG_RAMP: ramp_r = d[30:0];
      REG_TVOLT: tvolt_r = d[17:0];
      REG_STRENGTH: strength_r = d[15:0];
      default: ;
    endcase
  endfunction

  function automatic reading_t regulate(logic [87:0] w);
    cmd_t c;
    longint fr, nom, u1, u2, dp, st, sc, aim, d;
    bit slack;
    reading_t r;
    c = cmd_t'(w[1:0]);
    fr = w[25:2];
    nom = w[49:26];
    u1 = w[65:50];
    u2 = w[81:66];
    slack = (mode_r == MODE_SLACK);
    case (c)
      CMD_DROOP: if (!slack) begin
        dp = -round_shift(droop_r * 1000 * (fr - nom), 16);
        goal_s = bound_power(target_r + dp);
      end
      CMD_GOV: if (!slack) begin
        st = clip(round_shift(K_GOV * (goal_s - power_s), 16), -ramp_r, ramp_r);
        power_s = bound_power(power_s + st);
      end
      CMD_EXC: begin
        if (slack) volt_s = tvolt_r;
        else volt_s = volt_s + round_shift(K_EXC * (tvolt_r - volt_s), 16);
        volt_s = clip(volt_s, 0, 262143);
      end
      default: if (!slack) begin
        sc = 65536;
        case (mode_r)
          MODE_WIND: begin
            walk_s = clip(round_shift(K_WIND_AR * walk_s, 16)
                          + strength_of(scaled_draw(u1, -5243, 10486)),
                          -WALK_LIM, WALK_LIM);
            sc = 45875 + walk_s + scaled_draw(u2, -3277, 6554);
          end
          MODE_SOLAR: sc = 51118 + strength_of(scaled_draw(u1, -13107, 26214));
          MODE_HYDRO: sc = 60293 + strength_of(scaled_draw(u1, -3277, 7209));
          MODE_THERMAL: sc = 65536 + strength_of(scaled_draw(u1, -1311, 3277));
          default: ;
        endcase
        sc = clip(sc, SCALE_LO, SCALE_HI);
        aim = bound_power(round_shift(target_r * sc, 16));
        d = clip(aim - power_s, -ramp_r, ramp_r);
        power_s = bound_power(power_s + d);
        goal_s = power_s;
      end
    endcase
    r.power = power_s[31:0];
    r.goal = goal_s[31:0];
    r.voltage = volt_s[17:0];
    return r;
  endfunction

  function automatic logic [87:0] make_word(cmd_t c, logic [23:0] fr, logic [23:0] nom,
                                            logic [15:0] u1, logic [15:0] u2);
    return {6'd0, u2, u1, nom, fr, c};
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(regulate(in_tdata));
        cmd_count[in_tdata[1:0]]++;
        void'(pending_words.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (!quiet && send_gap == 0 && $urandom_range(0, 15) == 0)
          send_gap = $urandom_range(1, 16);
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!hold_off && pending_words.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_words[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[81:0];
        checked++;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (got.power !== want.power) begin
            $display("%0t: power expected %h actual %h", $time, want.power, got.power);
            errors++;
          end
          if (got.goal !== want.goal) begin
            $display("%0t: goal expected %h actual %h", $time, want.goal, got.goal);
            errors++;
          end
          if (got.voltage !== want.voltage) begin
            $display("%0t: voltage expected %h actual %h", $time, want.voltage,
                     got.voltage);
            errors++;
          end
        end
      end
      if (!quiet && take_gap == 0 && $urandom_range(0, 15) == 0)
        take_gap = $urandom_range(1, 16);
      if (take_gap > 0) begin
        take_gap = take_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress in %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_register(reg_idx_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_words.size() > 0 || expected_readings.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] random_power();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 60000000);
      2: return -$urandom_range(0, 20000000);
      default: return $urandom_range(0, 2000000);
    endcase
  endfunction

  function automatic logic [23:0] near_nominal(logic [23:0] nom);
    return nom + 24'($signed($urandom_range(0, 40000)) - 20000);
  endfunction

  task automatic queue_random(int n);
    cmd_t c;
    logic [23:0] nom;
    repeat (n) begin
      c = cmd_t'($urandom_range(0, 3));
      nom = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'd3276800;
      pending_words.push_back(make_word(c,
        ($urandom_range(0, 3) == 0) ? 24'($urandom()) : near_nominal(nom),
        nom, 16'($urandom()), 16'($urandom())));
    end
  endtask

  task automatic random_settings();
    write_register(REG_MODE, $urandom_range(0, 7));
    write_register(REG_TARGET, random_power());
    write_register(REG_MIN, ($urandom_range(0, 5) == 0) ? random_power() :
                   -$urandom_range(0, 1000000));
    write_register(REG_MAX, ($urandom_range(0, 5) == 0) ? random_power() :
                   $urandom_range(10000000, 80000000));
    write_register(REG_DROOP, ($urandom_range(0, 4) == 0) ? $urandom() :
                   $urandom_range(0, 8000));
    write_register(REG_RAMP, ($urandom_range(0, 4) == 0) ? {1'b0, 31'($urandom())} :
                   $urandom_range(0, 400000));
    write_register(REG_TVOLT, $urandom_range(0, 262143));
    write_register(REG_STRENGTH, $urandom_range(0, 65535));
  endtask

  initial begin
    mode_r = MODE_MANUAL;
    target_r = 0;
    min_r = 0;
    max_r = 51200000;
    droop_r = 5120;
    ramp_r = 128000;
    tvolt_r = 65536;
    strength_r = 4096;
    power_s = 0;
    goal_s = 0;
    volt_s = 65536;
    walk_s = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and every operation in manual mode.
    write_register(REG_TARGET, 32'd20000000);
    pending_words.push_back(make_word(CMD_DROOP, 24'd3276800, 24'd3276800, 16'd0, 16'd0));
    pending_words.push_back(make_word(CMD_DROOP, 24'hFFFFFF, 24'd0, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_word(CMD_DROOP, 24'd0, 24'hFFFFFF, 16'd0, 16'd0));
    pending_words.push_back(make_word(CMD_DROOP, 24'd3270000, 24'd3276800, 16'd0, 16'd0));
    pending_words.push_back(make_word(CMD_GOV, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'd0));
    pending_words.push_back(make_word(CMD_GOV, 24'd0, 24'd0, 16'd0, 16'd0));
    pending_words.push_back(make_word(CMD_EXC, 24'hFFFFFF, 24'd0, 16'd0, 16'hFFFF));
    pending_words.push_back(make_word(CMD_TICK, 24'd0, 24'd0, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_word(CMD_TICK, 24'd0, 24'd0, 16'd0, 16'd0));
    drain();
    // Profile modes including the undefined ones, with extreme draws.
    for (int m = 0; m < 8; m++) begin
      write_register(REG_MODE, m);
      write_register(REG_TVOLT, (m % 2) ? 32'h3FFFF : 32'd0);
      pending_words.push_back(make_word(CMD_TICK, 24'd0, 24'd0, 16'hFFFF, 16'd0));
      pending_words.push_back(make_word(CMD_TICK, 24'd0, 24'd0, 16'd0, 16'hFFFF));
      pending_words.push_back(make_word(CMD_EXC, 24'd0, 24'd0, 16'd0, 16'd0));
      pending_words.push_back(make_word(CMD_DROOP, 24'd3200000, 24'd3276800, 16'd0, 16'd0));
      drain();
    end
    // Crossed limits and register extremes.
    write_register(REG_MODE, 32'(MODE_MANUAL));
    write_register(REG_MIN, 32'd40000000);
    write_register(REG_MAX, 32'd1000);
    write_register(REG_DROOP, 32'hFFFF);
    write_register(REG_RAMP, 32'h7FFFFFFF);
    write_register(REG_STRENGTH, 32'hFFFF);
    write_register(REG_TARGET, 32'h80000000);
    queue_random(8);
    drain();
    write_register(REG_MIN, 32'h80000000);
    write_register(REG_MAX, 32'h7FFFFFFF);
    write_register(REG_TARGET, 32'h7FFFFFFF);
    write_register(REG_RAMP, 32'd0);
    write_register(REG_STRENGTH, 32'd0);
    queue_random(8);
    drain();

    // Random phases; the sender holds off once until the results catch up.
    for (int p = 0; p < 12; p++) begin
      random_settings();
      queue_random(100);
      if (p == 5) begin
        hold_off = 1'b1;
        while (expected_readings.size() > 0 ||
               (pending_words.size() > 0 && in_tvalid)) @(posedge clk);
        hold_off = 1'b0;
      end
      if (p == 11) quiet = 1'b1;
      drain();
    end

    $display("covered %0d results: droop %0d, governor %0d, exciter %0d, tick %0d",
             checked, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("over all eight modes with crossed and extreme limits");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
src/gdrg_pkg.sv
src/generator_droop_ramp_governor_top.sv
dv/tb.sv
